@@ rtl/core/orvt_pkg.sv @@
// orvt_pkg: types, constants and the hit weight table for the ocr result vote table
// no dependencies; imported by ocr_result_vote_table

package orvt_pkg;

   // fixed field widths of the stream items
   localparam int TEXT_IN_W  = 256;
   localparam int PROB_W     = 16;
   localparam int HITS_W     = 8;
   localparam int WEIGHT_W   = 16;
   localparam int SCORE_W    = PROB_W + WEIGHT_W;
   localparam int CC_W       = 6;
   localparam int REQ_DATA_W = TEXT_IN_W + PROB_W;

   localparam logic [CC_W-1:0]   CHAR_COUNT_RESET = 6'd10;
   localparam logic [HITS_W-1:0] HITS_MAX         = 8'd255;
   localparam logic [HITS_W-1:0] FEW_HITS         = 8'd3;

   // item kinds carried in tuser
   localparam logic KIND_ADD   = 1'b0;
   localparam logic KIND_CLEAR = 1'b1;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE,
      ST_RANK,
      ST_FETCH,
      ST_LOAD
   } state_type;

   // per-entry statistics word
   typedef struct packed {
      logic [HITS_W-1:0] hits;
      logic [PROB_W-1:0] prob;
   } stat_type;

   typedef logic [WEIGHT_W-1:0] weight_rom_type [256];

   // largest w with w^20 <= 2^280 * h^3, i.e. floor(16384 * h^0.15) in Q2.14
   function automatic logic [WEIGHT_W-1:0] weight_of(input int unsigned h);
      logic [319:0] lhs;
      logic [319:0] rhs;
      logic [31:0]  lo;
      logic [31:0]  hi;
      logic [31:0]  mid;
      rhs = 320'(h * h * h) << 280;
      lo  = 32'd0;
      hi  = 32'd65535;
      for (int k = 0; k < 17; k++) begin
         if (lo < hi) begin
            mid = lo + ((hi - lo + 32'd1) >> 1);
            lhs = 320'd1;
            for (int i = 0; i < 20; i++) begin
               lhs = lhs * 320'(mid);
            end
            if (lhs <= rhs) begin
               lo = mid;
            end else begin
               hi = mid - 32'd1;
            end
         end
      end
      return WEIGHT_W'(lo);
   endfunction

   function automatic weight_rom_type build_weight_rom();
      weight_rom_type rom;
      rom[0] = '0;
      for (int h = 1; h < 256; h++) begin
         rom[h] = weight_of(h);
      end
      return rom;
   endfunction

   localparam weight_rom_type WEIGHT_ROM = build_weight_rom();

endpackage

@@ rtl/core/ocr_result_vote_table.sv @@
// ocr_result_vote_table: vote table over recognized strings, one result per item
// uses orvt_pkg (types, constants, weight table); text and statistics in two memories
//
// Sequence: an add item goes through scan, write-back, rank, fetch and load from accept to
//   result, a clear item through rank, fetch and load
// Throughput: one item at a time; the next item is taken in the cycle after the result
//   is loaded into the output register
// Reset: synchronous, active high; clears the occupied count and control state and sets
//   char_count to 10; table memories are not cleared (entries past the count never reach a result)

module ocr_result_vote_table #(
   parameter  int TABLE_ENTRIES = 16,
   parameter  int MAX_BYTES     = 32,
   localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1),
   localparam int RSP_DATA_W    =
      ((orvt_pkg::TEXT_IN_W + orvt_pkg::PROB_W + CNT_W + 7) / 8) * 8
) (
   input  logic                            clock,
   input  logic                            reset,
   // request stream
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // text_bytes_0, text_bytes_1, text_bytes_2, text_bytes_3, probability
   input  logic [orvt_pkg::REQ_DATA_W-1:0] req_tdata,
   // kind
   input  logic [0:0]                      req_tuser,
   // char_count register write
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [orvt_pkg::CC_W-1:0]       csr_data,
   // result stream
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // best_bytes_0, best_bytes_1, best_bytes_2, best_bytes_3, best_probability,
   // entries_used, zero fill
   output logic [RSP_DATA_W-1:0]           rsp_tdata,
   // best_valid, matched_existing
   output logic [1:0]                      rsp_tuser
);
   import orvt_pkg::*;

   localparam int IDX_W  = $clog2(TABLE_ENTRIES);
   localparam int TEXT_W = MAX_BYTES * 8;
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_ENTRIES);
   localparam logic [CC_W-1:0]  MAX_CC     = CC_W'(MAX_BYTES);

   // table memories
   logic [TEXT_W-1:0] text_mem [TABLE_ENTRIES];
   stat_type          stat_mem [TABLE_ENTRIES];

   // control state
   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff;
   logic [CC_W-1:0]   char_count_ff;
   logic [CNT_W-1:0]  iss_ff;
   logic              rd_vld_ff;
   logic [IDX_W-1:0]  rd_idx_ff;
   logic              s2_vld_ff;
   logic              s3_vld_ff;
   logic              match_found_ff;
   logic              rsp_tvalid_ff;

   // current item
   logic [TEXT_W-1:0]    item_text_ff;
   logic [PROB_W-1:0]    item_prob_ff;
   logic [MAX_BYTES-1:0] byte_mask_ff;

   // scan results
   logic [IDX_W-1:0]  match_idx_ff;
   stat_type          match_stat_ff;
   logic [IDX_W-1:0]  victim_idx_ff;
   stat_type          victim_stat_ff;

   // ranking pipeline
   logic [IDX_W-1:0]    s2_idx_ff, s3_idx_ff;
   logic [WEIGHT_W-1:0] s2_weight_ff;
   logic [PROB_W-1:0]   s2_prob_ff, s3_prob_ff;
   logic [SCORE_W-1:0]  s3_score_ff;
   logic [SCORE_W-1:0]  best_score_ff;
   logic [IDX_W-1:0]    best_idx_ff;
   logic [PROB_W-1:0]   best_prob_ff;

   // memory read data
   logic [TEXT_W-1:0] txt_rd_ff;
   stat_type          st_rd_ff;

   // output payload
   logic [TEXT_IN_W-1:0] rsp_text_ff;
   logic [PROB_W-1:0]    rsp_prob_ff;
   logic [CNT_W-1:0]     rsp_count_ff;
   logic                 rsp_best_valid_ff;
   logic                 rsp_matched_ff;

   // combinational
   logic                 req_fire;
   logic                 issue;
   logic                 scan_done;
   logic                 rank_done;
   logic                 out_free;
   logic [CC_W-1:0]      n_bytes;
   logic [MAX_BYTES-1:0] byte_mask_in;
   logic [TEXT_W-1:0]    item_text_in;
   logic [MAX_BYTES-1:0] byte_diff;
   logic                 entry_eq;
   logic                 victim_better;
   logic                 replace_ok;
   logic                 txt_rd_en, st_rd_en, txt_we, st_we, count_inc;
   logic [IDX_W-1:0]     rd_addr, wr_addr;
   stat_type             st_wdata;
   logic [MAX_BYTES-1:0] zero_byte;
   logic [MAX_BYTES-1:0] keep_byte;
   logic [TEXT_IN_W-1:0] out_text;

   assign req_fire  = req_tvalid && req_tready;
   assign out_free  = !rsp_tvalid_ff || rsp_tready;
   assign issue     = ((state_ff == ST_SCAN) || (state_ff == ST_RANK)) && (iss_ff != count_ff);
   assign scan_done = (iss_ff == count_ff) && !rd_vld_ff;
   assign rank_done = (iss_ff == count_ff) && !rd_vld_ff && !s2_vld_ff && !s3_vld_ff;

   // compared byte count and masked item text
   always_comb begin
      n_bytes = (char_count_ff > MAX_CC) ? MAX_CC : char_count_ff;
      for (int i = 0; i < MAX_BYTES; i++) begin
         byte_mask_in[i]      = CC_W'(i) < n_bytes;
         item_text_in[8*i +: 8] = req_tdata[8*i +: 8] & {8{byte_mask_in[i]}};
      end
   end

   // entry compare against the item, on bytes inside the mask
   always_comb begin
      for (int i = 0; i < MAX_BYTES; i++) begin
         byte_diff[i] = byte_mask_ff[i] && (txt_rd_ff[8*i +: 8] != item_text_ff[8*i +: 8]);
      end
      entry_eq = ~|byte_diff;
   end

   // fewer hits, then lower probability, makes a better victim
   assign victim_better = (st_rd_ff.hits < victim_stat_ff.hits) ||
                          ((st_rd_ff.hits == victim_stat_ff.hits) &&
                           (st_rd_ff.prob < victim_stat_ff.prob));

   assign replace_ok = (victim_stat_ff.prob < item_prob_ff) &&
                       ((victim_stat_ff.hits < FEW_HITS) ||
                        ({victim_stat_ff.prob, 1'b0} < {1'b0, item_prob_ff}));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = (req_tuser[0] == KIND_CLEAR) ? ST_RANK : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: state_in = ST_RANK;
         ST_RANK: begin
            if (rank_done) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: state_in = ST_LOAD;
         ST_LOAD: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs: handshake, memory reads and the write-back
   always_comb begin
      req_tready = 1'b0;
      txt_rd_en  = 1'b0;
      st_rd_en   = 1'b0;
      rd_addr    = iss_ff[IDX_W-1:0];
      txt_we     = 1'b0;
      st_we      = 1'b0;
      wr_addr    = match_idx_ff;
      st_wdata   = match_stat_ff;
      count_inc  = 1'b0;
      case (state_ff)
         ST_IDLE: req_tready = 1'b1;
         ST_SCAN: begin
            txt_rd_en = issue;
            st_rd_en  = issue;
         end
         ST_UPDATE: begin
            if (match_found_ff) begin
               st_we         = 1'b1;
               wr_addr       = match_idx_ff;
               st_wdata.hits = (match_stat_ff.hits < HITS_MAX) ?
                               match_stat_ff.hits + 8'd1 : match_stat_ff.hits;
               st_wdata.prob = (item_prob_ff > match_stat_ff.prob) ?
                               item_prob_ff : match_stat_ff.prob;
            end else if (count_ff != FULL_COUNT) begin
               txt_we        = 1'b1;
               st_we         = 1'b1;
               count_inc     = 1'b1;
               wr_addr       = count_ff[IDX_W-1:0];
               st_wdata.hits = 8'd1;
               st_wdata.prob = item_prob_ff;
            end else if (replace_ok) begin
               txt_we        = 1'b1;
               st_we         = 1'b1;
               wr_addr       = victim_idx_ff;
               st_wdata.hits = 8'd1;
               st_wdata.prob = item_prob_ff;
            end
         end
         ST_RANK: st_rd_en = issue;
         ST_FETCH: begin
            txt_rd_en = 1'b1;
            rd_addr   = best_idx_ff;
         end
         ST_LOAD: ;
         default: ;
      endcase
   end

   // table memories, one write and one read port each
   always_ff @(posedge clock) begin
      if (txt_we) begin
         text_mem[wr_addr] <= item_text_ff;
      end
      if (txt_rd_en) begin
         txt_rd_ff <= text_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (st_we) begin
         stat_mem[wr_addr] <= st_wdata;
      end
      if (st_rd_en) begin
         st_rd_ff <= stat_mem[rd_addr];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         count_ff       <= '0;
         char_count_ff  <= CHAR_COUNT_RESET;
         iss_ff         <= '0;
         rd_vld_ff      <= 1'b0;
         s2_vld_ff      <= 1'b0;
         s3_vld_ff      <= 1'b0;
         match_found_ff <= 1'b0;
         rsp_tvalid_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= issue;
         s2_vld_ff <= rd_vld_ff && (state_ff == ST_RANK);
         s3_vld_ff <= s2_vld_ff;
         if (csr_valid && csr_ready) begin
            char_count_ff <= csr_data;
         end
         // issue counter restarts for each pass
         if (req_fire || (state_ff == ST_UPDATE)) begin
            iss_ff <= '0;
         end else if (issue) begin
            iss_ff <= iss_ff + 1'b1;
         end
         // occupied count
         if (req_fire && (req_tuser[0] == KIND_CLEAR)) begin
            count_ff <= '0;
         end else if (count_inc) begin
            count_ff <= count_ff + 1'b1;
         end
         // first matching entry wins
         if (req_fire) begin
            match_found_ff <= 1'b0;
         end else if (rd_vld_ff && (state_ff == ST_SCAN) && entry_eq) begin
            match_found_ff <= 1'b1;
         end
         // output register
         if ((state_ff == ST_LOAD) && out_free) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   // item capture, scan and ranking datapath
   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_text_ff <= item_text_in;
         item_prob_ff <= req_tdata[TEXT_IN_W +: PROB_W];
         byte_mask_ff <= byte_mask_in;
      end
      rd_idx_ff <= iss_ff[IDX_W-1:0];
      // match and victim search
      if (rd_vld_ff && (state_ff == ST_SCAN)) begin
         if (entry_eq && !match_found_ff) begin
            match_idx_ff  <= rd_idx_ff;
            match_stat_ff <= st_rd_ff;
         end
         if ((rd_idx_ff == '0) || victim_better) begin
            victim_idx_ff  <= rd_idx_ff;
            victim_stat_ff <= st_rd_ff;
         end
      end
      // weight lookup, then product, then compare
      s2_idx_ff    <= rd_idx_ff;
      s2_weight_ff <= WEIGHT_ROM[st_rd_ff.hits];
      s2_prob_ff   <= st_rd_ff.prob;
      s3_idx_ff    <= s2_idx_ff;
      s3_prob_ff   <= s2_prob_ff;
      s3_score_ff  <= s2_prob_ff * s2_weight_ff;
      if (s3_vld_ff && ((s3_idx_ff == '0) || (s3_score_ff > best_score_ff))) begin
         best_score_ff <= s3_score_ff;
         best_idx_ff   <= s3_idx_ff;
         best_prob_ff  <= s3_prob_ff;
      end
   end

   // bytes from the first zero byte onward read as zero
   always_comb begin
      out_text = '0;
      for (int i = 0; i < MAX_BYTES; i++) begin
         zero_byte[i] = txt_rd_ff[8*i +: 8] == 8'h00;
      end
      for (int i = 0; i < MAX_BYTES; i++) begin
         keep_byte[i] = 1'b1;
         for (int j = 0; j < MAX_BYTES; j++) begin
            if ((j <= i) && zero_byte[j]) begin
               keep_byte[i] = 1'b0;
            end
         end
         out_text[8*i +: 8] = keep_byte[i] ? txt_rd_ff[8*i +: 8] : 8'h00;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if ((state_ff == ST_LOAD) && out_free) begin
         rsp_count_ff      <= count_ff;
         rsp_matched_ff    <= match_found_ff;
         rsp_best_valid_ff <= count_ff != '0;
         rsp_text_ff       <= (count_ff != '0) ? out_text : '0;
         rsp_prob_ff       <= (count_ff != '0) ? best_prob_ff : '0;
      end
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_count_ff, rsp_prob_ff, rsp_text_ff});
   assign rsp_tuser  = {rsp_matched_ff, rsp_best_valid_ff};

   // a clear item empties the table
   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_tuser[0] == KIND_CLEAR)) |=> (count_ff == '0))
      else $error("clear item did not empty the table");

   // table memories are written only in the write-back step
   a_write_in_update: assert property (@(posedge clock) disable iff (reset)
      (txt_we || st_we) |-> (state_ff == ST_UPDATE))
      else $error("table write outside write-back");

   // the occupied count grows by one entry at a time
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (count_ff > $past(count_ff)) |-> (count_ff == CNT_W'($past(count_ff) + 1'b1)))
      else $error("occupied count jumped");

   // an empty-table result carries no probability and no match
   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && !rsp_best_valid_ff) |-> ((rsp_prob_ff == '0) && !rsp_matched_ff))
      else $error("empty table result not zero");

endmodule
